// ===== design/sss_pkg.sv =====
// Shared types and constants for the sequential switch.
// Holds the item and configuration structs, the trigger state encoding and
// the position range tables. Depends on nothing.
package sss_pkg;

    localparam int VW = 16;
    localparam int VOLT = 1024;
    localparam int DEN_MAX = 10240;

    localparam logic signed [VW-1:0] LEVEL_HIGH = 16'sd1024;
    localparam logic signed [VW-1:0] LEVEL_LOW  = 16'sd0;

    localparam logic [1:0] REG_HOLD_MODE = 2'd0;
    localparam logic [1:0] REG_CV_RANGE  = 2'd1;
    localparam logic [1:0] REG_STEP_KNOB = 2'd2;

    localparam logic [1:0] RANGE_0_8V    = 2'd0;
    localparam logic [1:0] RANGE_0_6V    = 2'd1;
    localparam logic [1:0] RANGE_0_10V   = 2'd2;
    localparam logic [1:0] RANGE_BIPOLAR = 2'd3;

    localparam logic [3:0] KNOB_RESET = 4'd8;

    typedef enum logic [2:0] {
        TRIG_UNKNOWN = 3'b001,
        TRIG_LOW     = 3'b010,
        TRIG_HIGH    = 3'b100
    } t_trig_state;

    typedef struct packed {
        logic       hold_mode;
        logic [1:0] cv_range;
        logic [3:0] step_knob;
    } t_cfg;

    typedef struct packed {
        logic signed [VW-1:0] signal_in;
        logic signed [VW-1:0] position_cv;
        logic                 position_cv_on;
        logic signed [VW-1:0] up_level;
        logic                 up_on;
        logic signed [VW-1:0] down_level;
        logic                 down_on;
        logic signed [VW-1:0] restart_level;
        logic                 restart_on;
        logic signed [VW-1:0] count_cv;
        logic                 count_cv_on;
        logic [7:0]           button_levels;
    } t_item;

    function automatic logic signed [VW-1:0] range_lo(input logic [1:0] r);
        logic signed [VW-1:0] v;
        unique case (r)
            RANGE_0_8V:    v = 16'sd0;
            RANGE_0_6V:    v = 16'sd0;
            RANGE_0_10V:   v = 16'sd0;
            RANGE_BIPOLAR: v = -16'sd5120;
            default:       v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [13:0] range_den(input logic [1:0] r);
        logic [13:0] v;
        unique case (r)
            RANGE_0_8V:    v = 14'd8192;
            RANGE_0_6V:    v = 14'd6144;
            RANGE_0_10V:   v = 14'd10240;
            RANGE_BIPOLAR: v = 14'd10240;
            default:       v = 14'd8192;
        endcase
        return v;
    endfunction

endpackage

// ===== design/sss_if.sv =====
// Valid/ready channel interfaces for the sequential switch.
// One carries input requests, the other result requests. No dependencies.
interface sss_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  signal_in;
    logic signed [15:0]  position_cv;
    logic                position_cv_on;
    logic signed [15:0]  up_level;
    logic                up_on;
    logic signed [15:0]  down_level;
    logic                down_on;
    logic signed [15:0]  restart_level;
    logic                restart_on;
    logic signed [15:0]  count_cv;
    logic                count_cv_on;
    logic [7:0]          button_levels;

    modport source(
        output valid, signal_in, position_cv, position_cv_on, up_level, up_on,
               down_level, down_on, restart_level, restart_on, count_cv,
               count_cv_on, button_levels,
        input  ready
    );
    modport sink(
        input  valid, signal_in, position_cv, position_cv_on, up_level, up_on,
               down_level, down_on, restart_level, restart_on, count_cv,
               count_cv_on, button_levels,
        output ready
    );
endinterface

interface sss_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  out_a;
    logic signed [15:0]  out_b;
    logic signed [15:0]  out_c;
    logic signed [15:0]  out_d;
    logic signed [15:0]  out_e;
    logic signed [15:0]  out_f;
    logic signed [15:0]  out_g;
    logic signed [15:0]  out_h;
    logic [2:0]          selected_step;

    modport source(
        output valid, out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h,
               selected_step,
        input  ready
    );
    modport sink(
        input  valid, out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h,
               selected_step,
        output ready
    );
endinterface

// ===== design/sequential_switch_one_to_eight.sv =====
// Sequential switch, one input to eight outputs: top level.
// Depends on sss_pkg, sss_if, sss_trig, sss_pos and sss_apb.
//
// Each request on i_in carries one sample of the routed voltage together with
// the position, gate, step count and button inputs. The block answers every
// request with one result request on o_out: the eight output voltages and the
// selected step. The user writes configuration through the APB-style port
// only while the block is idle; this is not enforced. pready is always high.
//
// A request is registered in the input register at the edge that accepts it;
// its result is registered in the output register when the request advances,
// once the result register is empty or being taken. One request is accepted in
// every cycle as long as the result side keeps taking results. When the
// receiver stalls, the pending result holds and one more request can wait in
// the input register; after that i_in.ready drops until the result is taken.
//
// Reset selects step 0, clears all outputs, puts every trigger in the unknown
// state and loads hold_mode 0, cv_range 0 and step_knob 8.
module sequential_switch_one_to_eight import sss_pkg::*; #(
    parameter int STEP_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sss_in_if.sink      i_in,
    sss_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW  = $clog2(STEP_COUNT + 1);
    localparam int PW  = $clog2(STEP_COUNT);
    localparam int PSW = CW + 1;
    localparam int MW  = 2 * CW + 1;
    localparam int NH  = (STEP_COUNT < 8) ? STEP_COUNT : 8;
    localparam int SW  = (PW > 3) ? PW : 3;

    t_cfg w_cfg;

    t_item r_item;
    logic  r_s1_valid;
    logic  n_s1_valid;
    logic  r_out_valid;
    logic  n_out_valid;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] n_cur;
    logic signed [VW-1:0] r_held [NH];
    logic signed [VW-1:0] n_held [NH];

    logic w_adv;
    logic w_in_acc;
    logic w_gate_en;
    logic [CW-1:0] w_n;
    logic [PW-1:0] w_pos;
    logic w_fire_up;
    logic w_fire_down;
    logic w_fire_restart;
    logic [STEP_COUNT-1:0] w_btn_fire;
    logic w_btn_hit;
    logic [PW-1:0] w_btn_idx;
    logic signed [PSW-1:0] w_p_gate;
    logic [MW-1:0] w_pu;
    logic [PW-1:0] w_mod;
    logic signed [VW-1:0] w_outs [8];
    logic [SW-1:0] w_sel;

    sss_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_in_acc = i_in.valid && i_in.ready;

    assign n_s1_valid  = w_in_acc || (r_s1_valid && !w_adv);
    assign n_out_valid = w_adv || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.signal_in      <= i_in.signal_in;
            r_item.position_cv    <= i_in.position_cv;
            r_item.position_cv_on <= i_in.position_cv_on;
            r_item.up_level       <= i_in.up_level;
            r_item.up_on          <= i_in.up_on;
            r_item.down_level     <= i_in.down_level;
            r_item.down_on        <= i_in.down_on;
            r_item.restart_level  <= i_in.restart_level;
            r_item.restart_on     <= i_in.restart_on;
            r_item.count_cv       <= i_in.count_cv;
            r_item.count_cv_on    <= i_in.count_cv_on;
            r_item.button_levels  <= i_in.button_levels;
        end
    end

    sss_pos #(.STEP_COUNT(STEP_COUNT)) u_pos (
        .i_cfg         (w_cfg),
        .i_count_cv    (r_item.count_cv),
        .i_count_cv_on (r_item.count_cv_on),
        .i_position_cv (r_item.position_cv),
        .o_count       (w_n),
        .o_pos         (w_pos)
    );

    assign w_gate_en = w_adv && !r_item.position_cv_on;

    sss_trig u_trig_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_gate_en && r_item.up_on),
        .i_high  ($signed(r_item.up_level) >= LEVEL_HIGH),
        .i_low   ($signed(r_item.up_level) <= LEVEL_LOW),
        .o_fire  (w_fire_up)
    );

    sss_trig u_trig_down (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_gate_en && r_item.down_on),
        .i_high  ($signed(r_item.down_level) >= LEVEL_HIGH),
        .i_low   ($signed(r_item.down_level) <= LEVEL_LOW),
        .o_fire  (w_fire_down)
    );

    sss_trig u_trig_restart (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_gate_en && r_item.restart_on),
        .i_high  ($signed(r_item.restart_level) >= LEVEL_HIGH),
        .i_low   ($signed(r_item.restart_level) <= LEVEL_LOW),
        .o_fire  (w_fire_restart)
    );

    for (genvar gi = 0; gi < STEP_COUNT; gi++) begin : g_btn
        logic w_level;
        if (gi < 8) begin : g_wired
            assign w_level = r_item.button_levels[gi];
        end else begin : g_open
            assign w_level = 1'b0;
        end
        sss_trig u_trig_btn (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv && (CW'(gi) < w_n)),
            .i_high  (w_level),
            .i_low   (!w_level),
            .o_fire  (w_btn_fire[gi])
        );
    end

    always_comb begin
        w_btn_hit = 1'b0;
        w_btn_idx = '0;
        for (int i = 0; i < STEP_COUNT; i++) begin
            if (w_btn_fire[i]) begin
                w_btn_hit = 1'b1;
                w_btn_idx = PW'(i);
            end
        end
    end

    always_comb begin
        w_p_gate = $signed(PSW'(r_cur));
        if (w_fire_up) w_p_gate = w_p_gate + PSW'(1);
        if (w_fire_down) w_p_gate = w_p_gate - PSW'(1);
        if (w_fire_restart) w_p_gate = '0;
    end

    // The gate position lies between -1 and STEP_COUNT, so one quotient of
    // at most STEP_COUNT brings it back into the active steps.
    assign w_pu = MW'(unsigned'(w_p_gate));

    always_comb begin
        logic [MW-1:0] w_base;
        w_base = '0;
        w_mod = '0;
        if (w_p_gate < 0) begin
            w_mod = PW'(w_n - CW'(1));
        end else begin
            for (int q = 0; q <= STEP_COUNT; q++) begin
                w_base = MW'(q) * MW'(w_n);
                if (w_pu >= w_base && w_pu < w_base + MW'(w_n)) begin
                    w_mod = PW'(w_pu - w_base);
                end
            end
        end
    end

    always_comb begin
        n_cur = r_cur;
        if (w_adv) begin
            priority if (w_btn_hit) n_cur = w_btn_idx;
            else if (r_item.position_cv_on) n_cur = w_pos;
            else n_cur = w_mod;
        end
    end

    always_comb begin
        for (int j = 0; j < NH; j++) begin
            n_held[j] = r_held[j];
            if (w_adv) begin
                if (n_cur == PW'(j)) n_held[j] = r_item.signal_in;
                else if (!w_cfg.hold_mode) n_held[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            for (int j = 0; j < NH; j++) r_held[j] <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            for (int j = 0; j < NH; j++) r_held[j] <= n_held[j];
        end
    end

    for (genvar go = 0; go < 8; go++) begin : g_out
        if (go < NH) begin : g_step
            assign w_outs[go] = r_held[go];
        end else begin : g_none
            assign w_outs[go] = '0;
        end
    end

    assign w_sel = SW'(r_cur);

    assign o_out.valid         = r_out_valid;
    assign o_out.out_a         = w_outs[0];
    assign o_out.out_b         = w_outs[1];
    assign o_out.out_c         = w_outs[2];
    assign o_out.out_d         = w_outs[3];
    assign o_out.out_e         = w_outs[4];
    assign o_out.out_f         = w_outs[5];
    assign o_out.out_g         = w_outs[6];
    assign o_out.out_h         = w_outs[7];
    assign o_out.selected_step = w_sel[2:0];

    a_step_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_cur < $past(w_n))
        else $error("selected step outside the active steps");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> $stable(r_cur) && $stable(r_held[0]))
        else $error("result state changed while the receiver stalled");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");

endmodule

// ===== design/sss_trig.sv =====
// Schmitt trigger cell with unknown, low and high states.
// Fires on a low-to-high crossing. Depends on sss_pkg.
module sss_trig import sss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_high,
    input  logic i_low,
    output logic o_fire
);

    t_trig_state r_state;
    t_trig_state n_state;

    assign o_fire = i_en && (r_state == TRIG_LOW) && i_high;

    always_comb begin
        n_state = r_state;
        if (i_en) begin
            unique case (r_state)
                TRIG_LOW: begin
                    if (i_high) n_state = TRIG_HIGH;
                end
                TRIG_HIGH: begin
                    if (i_low) n_state = TRIG_LOW;
                end
                TRIG_UNKNOWN: begin
                    if (i_high) n_state = TRIG_HIGH;
                    else if (i_low) n_state = TRIG_LOW;
                end
                default: n_state = TRIG_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TRIG_UNKNOWN;
        end else begin
            r_state <= n_state;
        end
    end

    a_fire_goes_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire |=> r_state == TRIG_HIGH)
        else $error("trigger fired without reaching high");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_state))
        else $error("trigger moved while not clocked");

    a_known_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != TRIG_UNKNOWN |=> r_state != TRIG_UNKNOWN)
        else $error("trigger fell back to unknown");

endmodule

// ===== design/sss_pos.sv =====
// Step count and position voltage rescale for the sequential switch.
// Rounds the count voltage, clamps the knob and maps the position voltage
// onto the active steps by threshold compares. Depends on sss_pkg.
module sss_pos import sss_pkg::*; #(
    parameter int STEP_COUNT = 8,
    localparam int CW = $clog2(STEP_COUNT + 1),
    localparam int PW = $clog2(STEP_COUNT)
) (
    input  t_cfg                 i_cfg,
    input  logic signed [VW-1:0] i_count_cv,
    input  logic                 i_count_cv_on,
    input  logic signed [VW-1:0] i_position_cv,
    output logic [CW-1:0]        o_count,
    output logic [PW-1:0]        o_pos
);

    localparam int NW = $clog2(2 * DEN_MAX * STEP_COUNT) + 1;
    localparam logic signed [17:0] CNT_MIN = 18'(VOLT);
    localparam logic signed [17:0] CNT_MAX = 18'(STEP_COUNT * VOLT);

    logic [4:0]         w_knob;
    logic signed [17:0] w_cnt_v;
    logic signed [17:0] w_cnt_sum;
    logic [CW-1:0]      w_n;
    logic [CW-1:0]      w_m;
    logic signed [17:0] w_lo;
    logic signed [17:0] w_hi;
    logic [13:0]        w_den;
    logic signed [17:0] w_v;
    logic [13:0]        w_u;
    logic [NW-1:0]      w_num2;
    logic [STEP_COUNT-1:0] w_ge;

    always_comb begin
        w_knob = {1'b0, i_cfg.step_knob};
        if (w_knob == 5'd0) w_knob = 5'd1;
        else if (w_knob > 5'(STEP_COUNT)) w_knob = 5'(STEP_COUNT);

        w_cnt_v = 18'(i_count_cv);
        if (w_cnt_v < CNT_MIN) w_cnt_v = CNT_MIN;
        else if (w_cnt_v > CNT_MAX) w_cnt_v = CNT_MAX;
        w_cnt_sum = w_cnt_v + 18'sd512;

        if (i_count_cv_on) w_n = CW'(w_cnt_sum[17:10]);
        else w_n = CW'(w_knob);
    end

    assign w_m = w_n - CW'(1);
    assign w_den = range_den(i_cfg.cv_range);
    assign w_lo = 18'(range_lo(i_cfg.cv_range));
    assign w_hi = w_lo + $signed({4'b0, w_den});

    always_comb begin
        w_v = 18'(i_position_cv);
        if (w_v < w_lo) w_v = w_lo;
        else if (w_v > w_hi) w_v = w_hi;
    end

    assign w_u = 14'(w_v - w_lo);
    assign w_num2 = NW'({w_u, 1'b0}) * NW'(w_m);

    // Position k is reached once the scaled voltage reaches (2k-1) half steps.
    always_comb begin
        w_ge = '0;
        for (int k = 1; k < STEP_COUNT; k++) begin
            w_ge[k] = w_num2 >= NW'(2 * k - 1) * NW'(w_den);
        end
    end

    assign o_count = w_n;
    assign o_pos = PW'($countones(w_ge));

endmodule

// ===== design/sss_apb.sv =====
// Configuration registers of the sequential switch behind an APB-style port.
// Depends on sss_pkg for the register map and configuration struct.
module sss_apb import sss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (paddr[3:2])
                REG_HOLD_MODE: n_cfg.hold_mode = pwdata[0];
                REG_CV_RANGE:  n_cfg.cv_range  = pwdata[1:0];
                REG_STEP_KNOB: n_cfg.step_knob = pwdata[3:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HOLD_MODE: prdata = 32'(r_cfg.hold_mode);
            REG_CV_RANGE:  prdata = 32'(r_cfg.cv_range);
            REG_STEP_KNOB: prdata = 32'(r_cfg.step_knob);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_mode <= 1'b0;
            r_cfg.cv_range  <= RANGE_0_8V;
            r_cfg.step_knob <= KNOB_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
